/* rtl/msc_pkg.sv */
package msc_pkg;

   // field and datapath widths
   localparam int COUNT_WIDTH = 32;
   localparam int SPEED_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int CPR_W       = 16;
   localparam int US_W        = 16;
   localparam int PERIOD_W    = 20;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 3;
   localparam int INTEG_W     = 17;

   // serial multiplier: multiplicand, serial multiplier operand, product
   // product covers the 28-bit speed scale times a full count magnitude,
   // and at least the 48-bit integral increment
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = COUNT_WIDTH;
   localparam int PROD_W  = (COUNT_WIDTH + 28 > 48) ? (COUNT_WIDTH + 28) : 48;

   // serial divider: dividend, divisor, saturated quotient
   localparam int DIV_NUM_W = PROD_W;
   localparam int DIV_DEN_W = 32;
   localparam int QUOT_W    = 17;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // fixed-point alignment
   localparam int PROP_SHIFT  = 4;
   localparam int Q16_SHIFT   = 16;
   localparam int P_MAG_W     = GAIN_W + SPEED_W - PROP_SHIFT;
   localparam int INTEG_SUM_W = INTEG_W + 2;
   localparam int U_SUM_W     = P_MAG_W + 2;

   // constants of the control law
   localparam logic [MUL_A_W-1:0]   SPEED_SCALE   = 32'd256000000;
   localparam logic [DIV_DEN_W-1:0] INT_TIME_DIV  = 32'd1000000;
   localparam logic [PERIOD_W-1:0]  PERIOD_MAX    = 20'd1000000;
   localparam logic [INTEG_W-1:0]   ONE_Q16       = 17'h10000;
   localparam logic [SPEED_W-1:0]   SPD_LIMIT_POS = 16'h7fff;
   localparam logic [SPEED_W-1:0]   SPD_LIMIT_NEG = 16'h8000;

   // register reset values
   localparam logic [SPEED_W-1:0]  REF_SPEED_RESET = 16'd0;
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RESET = 16'd819;
   localparam logic [GAIN_W-1:0]   INT_GAIN_RESET  = 16'd512;
   localparam logic [CPR_W-1:0]    CPR_RESET       = 16'd80;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 20'd100000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_SPEED     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INT_GAIN      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPR           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_PERIOD_NS = 3'd4;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

/* rtl/msc_req_if.sv */
interface msc_req_if import msc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] encoder_count;
   logic [US_W-1:0]        elapsed_us;

   modport source (output valid, output encoder_count, output elapsed_us, input ready);
   modport sink (input valid, input encoder_count, input elapsed_us, output ready);
endinterface

/* rtl/msc_rsp_if.sv */
interface msc_rsp_if import msc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [PERIOD_W-1:0]       duty_ns;
   logic                      direction;
   logic signed [SPEED_W-1:0] measured_speed;

   modport source (output valid, output duty_ns, output direction, output measured_speed,
                   input ready);
   modport sink (input valid, input duty_ns, input direction, input measured_speed,
                 output ready);
endinterface

/* rtl/msc_csr_if.sv */
interface msc_csr_if import msc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/pi_motor_speed_controller.sv */
// pi speed controller with clamped integrator, bit-serial datapath
// req_if carries one sample tick per transaction: free-running encoder_count
// and elapsed_us since the previous tick. rsp_if returns one transaction per
// tick: duty_ns (pwm high time), direction (sign of the reference) and
// measured_speed (signed q8.8 rev/s). csr_if writes the five registers by
// index (ref_speed, prop_gain, int_gain, encoder counts per revolution,
// pwm_period_ns); it is ready whenever reset is low and should only be
// written while no tick is in flight.
// per tick: six products on a shift-add multiplier (one multiplier operand
// bit per step) and up to two 60-step restoring divisions; the speed
// division is skipped when elapsed_us or the count difference is zero.
// one tick is processed at a time; req_if.ready is high only between ticks,
// so a new tick is accepted only once the previous one has left the sequencer.
// the result sits in an output register: the next tick is accepted while it
// waits, and if rsp_if stalls the following result waits in the last step
// until the register frees up. reset clears the registers to their defaults,
// the previous count and the integrator to zero, and drops rsp_if.valid;
// no transaction is accepted while reset is high.
module pi_motor_speed_controller import msc_pkg::*; (
   input logic        clock,
   input logic        reset,
   msc_req_if.sink    req_if,
   msc_rsp_if.source  rsp_if,
   msc_csr_if.sink    csr_if
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_DEN  = 11'b00000000010,
      ST_NUM  = 11'b00000000100,
      ST_SPD  = 11'b00000001000,
      ST_ERR  = 11'b00000010000,
      ST_IG   = 11'b00000100000,
      ST_IGT  = 11'b00001000000,
      ST_IDIV = 11'b00010000000,
      ST_P    = 11'b00100000000,
      ST_DUTY = 11'b01000000000,
      ST_LOAD = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [SPEED_W-1:0]  ref_speed_ff;
   logic [GAIN_W-1:0]   prop_gain_ff;
   logic [GAIN_W-1:0]   int_gain_ff;
   logic [CPR_W-1:0]    cpr_ff;
   logic [PERIOD_W-1:0] period_ff;

   // loop state
   logic [COUNT_WIDTH-1:0] last_count_ff, last_count_in;
   logic [INTEG_W-1:0]     integ_ff, integ_in;

   // per-tick working registers
   logic                   neg_ff, neg_in;
   logic [COUNT_WIDTH-1:0] mag_ff, mag_in;
   logic [US_W-1:0]        us_ff, us_in;
   logic [DIV_DEN_W-1:0]   den_ff, den_in;
   logic [SPEED_W-1:0]     spd_mag_ff, spd_mag_in;
   logic                   e_neg_ff, e_neg_in;
   logic [SPEED_W-1:0]     e_mag_ff, e_mag_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0] duty_ff, duty_in;
   logic                direction_ff, direction_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;

   mul_cmd_type mul_cmd;
   mul_rsp_type mul_rsp;
   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic                   req_fire;
   logic                   csr_fire;
   logic [CPR_W-1:0]       cpr_eff;
   logic [PERIOD_W-1:0]    period_eff;
   logic [COUNT_WIDTH-1:0] cnt_diff;
   logic                   cnt_neg;
   logic [COUNT_WIDTH-1:0] cnt_mag;
   logic [SPEED_W-1:0]     spd_limit;
   logic [SPEED_W-1:0]     ref_mag;
   logic [SPEED_W:0]       err;
   logic [SPEED_W:0]       err_abs;
   logic                   err_neg;
   logic [SPEED_W-1:0]     err_mag;
   logic [INTEG_SUM_W-1:0] integ_sum;
   logic [INTEG_W-1:0]     integ_next;
   logic [P_MAG_W-1:0]     p_mag;
   logic [U_SUM_W-1:0]     u_sum;
   logic [INTEG_W-1:0]     u_next;

   msc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   msc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_fire     = csr_if.valid && csr_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_if.ready = !reset;

   // register write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_speed_ff <= REF_SPEED_RESET;
         prop_gain_ff <= PROP_GAIN_RESET;
         int_gain_ff  <= INT_GAIN_RESET;
         cpr_ff       <= CPR_RESET;
         period_ff    <= PERIOD_RESET;
      end else if (csr_fire) begin
         case (csr_if.index)
            CSR_REF_SPEED:     ref_speed_ff <= csr_if.data[SPEED_W-1:0];
            CSR_PROP_GAIN:     prop_gain_ff <= csr_if.data[GAIN_W-1:0];
            CSR_INT_GAIN:      int_gain_ff  <= csr_if.data[GAIN_W-1:0];
            CSR_CPR:           cpr_ff       <= csr_if.data[CPR_W-1:0];
            CSR_PWM_PERIOD_NS: period_ff    <= csr_if.data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // effective settings: zero counts per rev acts as one, period held to its max
   assign cpr_eff    = (cpr_ff == '0) ? CPR_W'(1) : cpr_ff;
   assign period_eff = (period_ff > PERIOD_MAX) ? PERIOD_MAX : period_ff;

   // wrapping count difference as sign and magnitude
   assign cnt_diff = req_if.encoder_count - last_count_ff;
   assign cnt_neg  = cnt_diff[COUNT_WIDTH-1];
   assign cnt_mag  = cnt_neg ? (~cnt_diff + 1'b1) : cnt_diff;

   assign spd_limit = neg_ff ? SPD_LIMIT_NEG : SPD_LIMIT_POS;

   // speed error on magnitudes
   assign ref_mag = ref_speed_ff[SPEED_W-1] ? (~ref_speed_ff + 1'b1) : ref_speed_ff;
   assign err     = {1'b0, ref_mag} - {1'b0, spd_mag_ff};
   assign err_neg = err[SPEED_W];
   assign err_abs = err_neg ? (~err + 1'b1) : err;
   assign err_mag = err_abs[SPEED_W-1:0];

   // integrator update with clamp to 0..1
   always_comb begin
      if (e_neg_ff) begin
         integ_sum = INTEG_SUM_W'(integ_ff) - INTEG_SUM_W'(div_rsp.quot);
      end else begin
         integ_sum = INTEG_SUM_W'(integ_ff) + INTEG_SUM_W'(div_rsp.quot);
      end
      if (integ_sum[INTEG_SUM_W-1]) begin
         integ_next = '0;
      end else if (integ_sum > INTEG_SUM_W'(ONE_Q16)) begin
         integ_next = ONE_Q16;
      end else begin
         integ_next = integ_sum[INTEG_W-1:0];
      end
   end

   // proportional term plus integrator, clamped to 0..1
   assign p_mag = mul_rsp.prod[PROP_SHIFT +: P_MAG_W];

   always_comb begin
      if (e_neg_ff) begin
         u_sum = U_SUM_W'(integ_ff) - U_SUM_W'(p_mag);
      end else begin
         u_sum = U_SUM_W'(integ_ff) + U_SUM_W'(p_mag);
      end
      if (u_sum[U_SUM_W-1]) begin
         u_next = '0;
      end else if (u_sum > U_SUM_W'(ONE_Q16)) begin
         u_next = ONE_Q16;
      end else begin
         u_next = u_sum[INTEG_W-1:0];
      end
   end

   // tick sequencer
   always_comb begin
      state_in      = state_ff;
      mul_cmd       = '0;
      div_cmd       = '0;
      last_count_in = last_count_ff;
      integ_in      = integ_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      us_in         = us_ff;
      den_in        = den_ff;
      spd_mag_in    = spd_mag_ff;
      e_neg_in      = e_neg_ff;
      e_mag_in      = e_mag_ff;
      rsp_valid_in  = rsp_valid_ff;
      duty_in       = duty_ff;
      direction_in  = direction_ff;
      speed_in      = speed_ff;

      // result taken by the receiver
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               last_count_in = req_if.encoder_count;
               neg_in        = cnt_neg;
               mag_in        = cnt_mag;
               us_in         = req_if.elapsed_us;
               mul_cmd.start = 1'b1;
               mul_cmd.a     = MUL_A_W'(cpr_eff);
               mul_cmd.b     = MUL_B_W'(req_if.elapsed_us);
               state_in      = ST_DEN;
            end
         end
         ST_DEN: begin
            // denominator counts per rev times elapsed_us
            if (mul_rsp.done) begin
               den_in        = mul_rsp.prod[DIV_DEN_W-1:0];
               mul_cmd.start = 1'b1;
               mul_cmd.a     = SPEED_SCALE;
               mul_cmd.b     = mag_ff;
               state_in      = ST_NUM;
            end
         end
         ST_NUM: begin
            if (mul_rsp.done) begin
               if ((us_ff == '0) || (mag_ff == '0)) begin
                  spd_mag_in = '0;
                  state_in   = ST_ERR;
               end else begin
                  div_cmd.start = 1'b1;
                  div_cmd.num   = mul_rsp.prod[DIV_NUM_W-1:0];
                  div_cmd.den   = den_ff;
                  state_in      = ST_SPD;
               end
            end
         end
         ST_SPD: begin
            if (div_rsp.done) begin
               if (div_rsp.quot > QUOT_W'(spd_limit)) begin
                  spd_mag_in = spd_limit;
               end else begin
                  spd_mag_in = div_rsp.quot[SPEED_W-1:0];
               end
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            e_neg_in      = err_neg;
            e_mag_in      = err_mag;
            mul_cmd.start = 1'b1;
            mul_cmd.a     = MUL_A_W'(int_gain_ff);
            mul_cmd.b     = MUL_B_W'(err_mag);
            state_in      = ST_IG;
         end
         ST_IG: begin
            if (mul_rsp.done) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = mul_rsp.prod[MUL_A_W-1:0];
               mul_cmd.b     = MUL_B_W'(us_ff);
               state_in      = ST_IGT;
            end
         end
         ST_IGT: begin
            // scale the integral increment from microseconds to seconds
            if (mul_rsp.done) begin
               div_cmd.start = 1'b1;
               div_cmd.num   = mul_rsp.prod[DIV_NUM_W-1:0];
               div_cmd.den   = INT_TIME_DIV;
               state_in      = ST_IDIV;
            end
         end
         ST_IDIV: begin
            if (div_rsp.done) begin
               integ_in      = integ_next;
               mul_cmd.start = 1'b1;
               mul_cmd.a     = MUL_A_W'(prop_gain_ff);
               mul_cmd.b     = MUL_B_W'(e_mag_ff);
               state_in      = ST_P;
            end
         end
         ST_P: begin
            if (mul_rsp.done) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = MUL_A_W'(period_eff);
               mul_cmd.b     = MUL_B_W'(u_next);
               state_in      = ST_DUTY;
            end
         end
         ST_DUTY: begin
            if (mul_rsp.done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               duty_in      = mul_rsp.prod[Q16_SHIFT +: PERIOD_W];
               direction_in = ref_speed_ff[SPEED_W-1];
               speed_in     = neg_ff ? (~spd_mag_ff + 1'b1) : spd_mag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_count_ff <= '0;
         integ_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_count_ff <= last_count_in;
         integ_ff      <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      us_ff        <= us_in;
      den_ff       <= den_in;
      spd_mag_ff   <= spd_mag_in;
      e_neg_ff     <= e_neg_in;
      e_mag_ff     <= e_mag_in;
      duty_ff      <= duty_in;
      direction_ff <= direction_in;
      speed_ff     <= speed_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.duty_ns        = duty_ff;
   assign rsp_if.direction      = direction_ff;
   assign rsp_if.measured_speed = speed_ff;

`ifndef NO_ASSERTIONS
   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      integ_ff <= ONE_Q16)
      else $error("integrator left its 0..1 range");

   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> duty_ff <= period_eff)
      else $error("duty exceeds the pwm period");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOAD))
      else $error("result presented without a finished tick");
`endif

endmodule

/* rtl/msc_mul.sv */
module msc_mul import msc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   logic               busy_ff, busy_in;
   logic [PROD_W-1:0]  a_ff, a_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic               last_step;

   // finished once no multiplier bits are left
   assign last_step = busy_ff && (b_ff == '0);

   // shift-add, one multiplier bit per cycle
   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         a_in    = PROD_W'(cmd.a);
         b_in    = cmd.b;
         acc_in  = '0;
      end else if (last_step) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = {a_ff[PROD_W-2:0], 1'b0};
         b_in = {1'b0, b_ff[MUL_B_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = last_step;
   assign rsp.prod = acc_ff;

endmodule

/* rtl/msc_div.sv */
module msc_div import msc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]    q_ff, q_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   trial_diff;
   logic                 ge;

   // restoring step: bring down one dividend bit and try the divisor
   assign trial      = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign ge         = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         ovf_in  = 1'b0;
         num_in  = cmd.num;
         den_in  = cmd.den;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
      end else if (busy_ff) begin
         rem_in = ge ? trial_diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         // quotient bits pushed past the top mark an overflow
         ovf_in = ovf_ff | q_ff[QUOT_W-1];
         q_in   = {q_ff[QUOT_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   // saturated quotient
   assign rsp.done = done_ff;
   assign rsp.quot = ovf_ff ? '1 : q_ff;

`ifndef NO_ASSERTIONS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still iterating");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> busy_ff && !done_ff)
      else $error("divider did not begin after start");
`endif

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import msc_pkg::*;

   // one expected controller output per tick
   typedef struct packed {
      logic [PERIOD_W-1:0] duty_ns;
      logic                direction;
      logic [SPEED_W-1:0]  measured_speed;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msc_req_if req_if();
   msc_rsp_if rsp_if();
   msc_csr_if csr_if();

   pi_motor_speed_controller u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // 12 ns clock
   always #6 clock = ~clock;

   // controller shadow: registers, previous count, integrator
   logic signed [SPEED_W-1:0] ref_speed_sh;
   logic [GAIN_W-1:0]         prop_gain_sh;
   logic [GAIN_W-1:0]         int_gain_sh;
   logic [CPR_W-1:0]          cpr_sh;
   logic [PERIOD_W-1:0]       period_sh;
   logic [COUNT_WIDTH-1:0]    prev_count_sh;
   longint                    integ_sh;

   tick_result_type        pending_results_q[$];
   logic [COUNT_WIDTH-1:0] last_sent_count = '0;
   bit                     fast_mode = 1'b0;
   int                     ticks_sent = 0;
   int                     results_checked = 0;
   int                     settings_applied = 0;
   int                     mismatches = 0;

   // clamp to the q0.16 unit interval
   function automatic longint clamp_unit(input longint v);
      longint unit;
      unit = longint'(ONE_Q16);
      if (v < 0) return 0;
      if (v > unit) return unit;
      return v;
   endfunction

   // speed, pi law and duty for one tick; advances the shadow state
   function automatic tick_result_type predict_tick(input logic [COUNT_WIDTH-1:0] count,
                                                    input logic [US_W-1:0] us);
      logic [COUNT_WIDTH-1:0] diff;
      logic [COUNT_WIDTH-1:0] mag;
      logic                   neg;
      longint unsigned        mag_w, us_w, cpr_w, spd_mag, limit;
      longint                 ref_w, ref_mag, err, kp, ki, ctrl, period_w;
      tick_result_type        res;
      diff = count - prev_count_sh;
      neg = diff[COUNT_WIDTH-1];
      mag = neg ? (~diff + 1'b1) : diff;
      prev_count_sh = count;
      mag_w = 64'(mag);
      us_w = 64'(us);
      cpr_w = (cpr_sh == '0) ? 64'd1 : 64'(cpr_sh);
      limit = neg ? 64'd32768 : 64'd32767;
      spd_mag = 64'd0;
      if (us_w != 0 && mag_w != 0) begin
         spd_mag = (mag_w * 64'd256000000) / (cpr_w * us_w);
         if (spd_mag > limit) spd_mag = limit;
      end
      // error between magnitudes, integrator clamped before the sum
      ref_w = longint'(ref_speed_sh);
      ref_mag = (ref_w < 0) ? -ref_w : ref_w;
      err = ref_mag - longint'(spd_mag);
      ki = longint'(int_gain_sh);
      kp = longint'(prop_gain_sh);
      integ_sh = clamp_unit(integ_sh + (ki * err * longint'(us_w)) / 1000000);
      ctrl = clamp_unit((kp * err) / 16 + integ_sh);
      period_w = longint'((period_sh > PERIOD_MAX) ? PERIOD_MAX : period_sh);
      res.duty_ns = PERIOD_W'((ctrl * period_w) >>> Q16_SHIFT);
      res.direction = ref_speed_sh[SPEED_W-1];
      res.measured_speed = neg ? SPEED_W'(-spd_mag) : SPEED_W'(spd_mag);
      return res;
   endfunction

   // shadow register write
   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_REF_SPEED:     ref_speed_sh = data[SPEED_W-1:0];
         CSR_PROP_GAIN:     prop_gain_sh = data[GAIN_W-1:0];
         CSR_INT_GAIN:      int_gain_sh = data[GAIN_W-1:0];
         CSR_CPR:           cpr_sh = data[CPR_W-1:0];
         CSR_PWM_PERIOD_NS: period_sh = data[PERIOD_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("ERROR: %s", msg);
   endtask

   // send one tick transaction after a random gap (no gap in fast mode)
   task automatic send_tick(input logic [COUNT_WIDTH-1:0] count, input logic [US_W-1:0] us);
      int gap;
      gap = fast_mode ? 0 : int'($urandom_range(0, 5));
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.encoder_count <= count;
      req_if.elapsed_us <= us;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_results_q.push_back(predict_tick(count, us));
      last_sent_count = count;
      ticks_sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results_q.size() != 0);
   endtask

   // write all five registers, block idle
   task automatic configure(input logic [SPEED_W-1:0] ref_v, input logic [GAIN_W-1:0] kp,
                            input logic [GAIN_W-1:0] ki, input logic [CPR_W-1:0] cpr,
                            input logic [PERIOD_W-1:0] period);
      logic [CSR_INDEX_W-1:0] idx [5];
      logic [CSR_DATA_W-1:0]  val [5];
      idx = '{CSR_REF_SPEED, CSR_PROP_GAIN, CSR_INT_GAIN, CSR_CPR, CSR_PWM_PERIOD_NS};
      val = '{CSR_DATA_W'(ref_v), CSR_DATA_W'(kp), CSR_DATA_W'(ki), CSR_DATA_W'(cpr),
              CSR_DATA_W'(period)};
      for (int i = 0; i < 5; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= idx[i];
         csr_if.data <= val[i];
         do @(posedge clock); while (csr_if.ready !== 1'b1);
         apply_csr(idx[i], val[i]);
      end
      csr_if.valid <= 1'b0;
      settings_applied++;
   endtask

   // compare one accepted result against the oldest expectation
   task automatic check_result();
      tick_result_type exp_res;
      results_checked++;
      if (pending_results_q.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with no tick pending",
                                   results_checked));
         return;
      end
      exp_res = pending_results_q.pop_front();
      if (rsp_if.duty_ns !== exp_res.duty_ns)
         report_mismatch($sformatf("result %0d duty_ns got %0d expected %0d",
                                   results_checked, rsp_if.duty_ns, exp_res.duty_ns));
      if (rsp_if.direction !== exp_res.direction)
         report_mismatch($sformatf("result %0d direction got %b expected %b",
                                   results_checked, rsp_if.direction, exp_res.direction));
      if (rsp_if.measured_speed !== exp_res.measured_speed)
         report_mismatch($sformatf("result %0d measured_speed got %0d expected %0d",
                                   results_checked, rsp_if.measured_speed,
                                   $signed(exp_res.measured_speed)));
   endtask

   // result side: random stalls outside fast mode, check each transaction
   initial begin : result_monitor
      int stall;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = fast_mode ? 0 : int'($urandom_range(0, 5));
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         check_result();
      end
   end

   // reset register values, motion from rest
   task automatic test_reset_defaults();
      send_tick(32'd8, 16'd10000);
      send_tick(32'd16, 16'd10000);
      send_tick(32'd24, 16'd10000);
   endtask

   // speed saturation both ways, zero and longest elapsed, count wrap
   task automatic test_speed_limits();
      wait_drained();
      configure(16'd2560, PROP_GAIN_RESET, INT_GAIN_RESET, CPR_RESET, PERIOD_RESET);
      send_tick(32'h8000_0017, 16'd1);
      send_tick(32'h0000_0017, 16'd1);
      send_tick(32'hffff_ffff, 16'd0);
      send_tick(32'hffff_ffff, 16'hffff);
      send_tick(32'h0000_0004, 16'hffff);
      send_tick(32'hffff_fff0, 16'd10);
   endtask

   // register extremes: zero counts per rev, period above and at max,
   // zero period, gains at both ends, integrator driven to both clamps
   task automatic test_register_extremes();
      wait_drained();
      configure(16'h8000, 16'hffff, 16'hffff, 16'h0000, 20'hfffff);
      send_tick(32'hffff_fff0, 16'hffff);
      send_tick(32'hffff_fff0, 16'd1000);
      send_tick(32'hffff_fff1, 16'hffff);
      wait_drained();
      configure(16'h7fff, 16'h0000, 16'hffff, 16'hffff, 20'h00000);
      send_tick(32'h0000_1000, 16'd100);
      wait_drained();
      configure(16'h0000, 16'hffff, 16'hffff, 16'h0001, PERIOD_MAX);
      send_tick(32'h0001_0000, 16'd1);
      send_tick(32'h0002_0000, 16'd50000);
      wait_drained();
      configure(16'h7fff, 16'h0001, 16'h0001, 16'hffff, 20'h00001);
      send_tick(32'h0002_0003, 16'd20000);
   endtask

   // random settings, mostly plausible motion with some noise
   task automatic test_random_phases();
      int                     span;
      int                     kind;
      int                     delta;
      logic [COUNT_WIDTH-1:0] count;
      logic [US_W-1:0]        us;
      logic [SPEED_W-1:0]     ref_v;
      for (int phase = 0; phase < 12; phase++) begin
         wait_drained();
         fast_mode = (phase % 4 == 3);
         ref_v = SPEED_W'($urandom_range(0, 12000));
         if ($urandom_range(0, 1) == 1) ref_v = -ref_v;
         case (phase)
            0: configure(16'h8000, 16'h0000, 16'h0000, 16'h0000, 20'h00000);
            1: configure(16'h7fff, 16'hffff, 16'hffff, 16'hffff, 20'hfffff);
            default: begin
               if ($urandom_range(0, 2) != 0)
                  configure(ref_v, GAIN_W'($urandom_range(0, 4096)),
                            GAIN_W'($urandom_range(0, 2048)),
                            CPR_W'($urandom_range(20, 200)),
                            PERIOD_W'($urandom_range(1000, 200000)));
               else
                  configure(SPEED_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                            CPR_W'($urandom), PERIOD_W'($urandom));
            end
         endcase
         span = ($urandom_range(0, 4) == 0) ? (1 << 20) : int'($urandom_range(1, 200));
         for (int n = 0; n < 90; n++) begin
            // hold off once until the block has fully drained
            if (phase == 2 && n == 45) wait_drained();
            kind = int'($urandom_range(0, 99));
            delta = int'($urandom_range(0, 2 * span)) - span;
            count = last_sent_count + COUNT_WIDTH'(delta);
            if (kind < 70) us = US_W'($urandom_range(2000, 20000));
            else if (kind < 82) us = US_W'($urandom_range(1, 300));
            else if (kind < 88) us = '0;
            else begin
               count = COUNT_WIDTH'($urandom);
               us = US_W'($urandom);
            end
            send_tick(count, us);
         end
      end
      fast_mode = 1'b0;
   endtask

   initial begin : stimulus
      req_if.valid = 1'b0;
      req_if.encoder_count = '0;
      req_if.elapsed_us = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      ref_speed_sh = REF_SPEED_RESET;
      prop_gain_sh = PROP_GAIN_RESET;
      int_gain_sh = INT_GAIN_RESET;
      cpr_sh = CPR_RESET;
      period_sh = PERIOD_RESET;
      prev_count_sh = '0;
      integ_sh = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_speed_limits();
      test_register_extremes();
      test_random_phases();

      wait_drained();
      repeat (300) @(posedge clock);
      if (pending_results_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results_q.size()));
      $display("run covered %0d ticks over %0d register settings, %0d results checked",
               ticks_sent, settings_applied, results_checked);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // timeout guard
   initial begin : watchdog
      #15_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/msc_pkg.sv
rtl/msc_req_if.sv
rtl/msc_rsp_if.sv
rtl/msc_csr_if.sv
rtl/msc_mul.sv
rtl/msc_div.sv
rtl/pi_motor_speed_controller.sv
tb/sv/tb_top.sv
